[sv/fta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_pkg
// Shared widths, register codes, reset values and structs of the fixed
// timestep accumulator.
// ----------------------------------------------------------------------------
package fta_pkg;

  localparam int STEP_W   = 20;
  localparam int FRAME_W  = 24;
  localparam int CAP_W    = 8;
  localparam int ALPHA_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS  = 2'd2;

  localparam logic [STEP_W-1:0]  FIXED_STEP_RST = 20'd16667;
  localparam logic [FRAME_W-1:0] MAX_FRAME_RST  = 24'd250000;
  localparam logic [CAP_W-1:0]   MAX_STEPS_RST  = 8'd8;

  typedef struct packed {
    logic [STEP_W-1:0]  fixed_step;
    logic [FRAME_W-1:0] max_frame;
    logic [CAP_W-1:0]   max_steps;
  } fta_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fta_div_stat_t;

endpackage

[sv/fta_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_cfg
// Configuration register file: fixed step, frame clamp and step cap.
// ----------------------------------------------------------------------------
module fta_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fta_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output fta_pkg::fta_cfg_t              cfg
);

  fta_pkg::fta_cfg_t regs;
  fta_pkg::fta_cfg_t regs_next;

  always_comb begin
    regs_next = regs;
    if (cfg_we) begin
      unique case (cfg_index)
        fta_pkg::CFG_FIXED_STEP: begin
          // drop a zero step, keep the old one
          if (cfg_wdata[fta_pkg::STEP_W-1:0] != '0) begin
            regs_next.fixed_step = cfg_wdata[fta_pkg::STEP_W-1:0];
          end
        end
        fta_pkg::CFG_MAX_FRAME: begin
          regs_next.max_frame = cfg_wdata[fta_pkg::FRAME_W-1:0];
        end
        fta_pkg::CFG_MAX_STEPS: begin
          regs_next.max_steps = cfg_wdata[fta_pkg::CAP_W-1:0];
        end
        default: begin
          regs_next = regs;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fixed_step <= fta_pkg::FIXED_STEP_RST;
      regs.max_frame  <= fta_pkg::MAX_FRAME_RST;
      regs.max_steps  <= fta_pkg::MAX_STEPS_RST;
    end else begin
      regs <= regs_next;
    end
  end

  assign cfg = regs;

endmodule

[sv/fta_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_div
// Iterative restoring divider, one quotient bit per cycle. The partial
// remainder can be preloaded so a second pass continues a division.
// ----------------------------------------------------------------------------
module fta_div #(
  parameter int DW = 25,
  parameter int CW = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fta_pkg::STEP_W-1:0]   rem_init,
  input  logic [DW-1:0]                dividend,
  input  logic [CW-1:0]                nbits,
  input  logic [fta_pkg::STEP_W-1:0]   divisor,
  output fta_pkg::fta_div_stat_t       stat,
  output logic [DW-1:0]                quotient,
  output logic [fta_pkg::STEP_W-1:0]   remainder
);

  logic [fta_pkg::STEP_W-1:0] rem;
  logic [DW-1:0]              dvd;
  logic [DW-1:0]              quo;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic                       done;

  logic [fta_pkg::STEP_W+1:0] trial;
  logic                       ge;

  assign trial = {1'b0, rem, dvd[DW-1]} - {2'b00, divisor};
  assign ge    = ~trial[fta_pkg::STEP_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nbits;
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      dvd <= dividend;
      quo <= '0;
    end else if (busy) begin
      // subtract when the shifted remainder reaches the divisor, else restore
      rem <= ge ? trial[fta_pkg::STEP_W-1:0] : {rem[fta_pkg::STEP_W-2:0], dvd[DW-1]};
      dvd <= {dvd[DW-2:0], 1'b0};
      quo <= {quo[DW-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

[sv/fixed_timestep_accumulator_unit.sv]
`timescale 1ns / 1ps
// Processing: the shared bit-serial divider first yields AW step-count bits, where
//   AW = max(min(TIME_BITS, 24), 20) + 1, then 16 fraction bits; a new frame
//   is accepted only after the previous result has moved to the output register.
// Reset (synchronous, rst high): accumulator cleared, registers to defaults.
// ----------------------------------------------------------------------------
// fixed_timestep_accumulator_unit
// Clamps frame time, adds it to the accumulator, counts fixed steps up to a
// cap and produces remainder and Q0.16 interpolation fraction.
// ----------------------------------------------------------------------------
module fixed_timestep_accumulator_unit #(
  parameter int TIME_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,   // [23:0] frame_dt
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] step_count, [27:8] remainder, [43:28] alpha, [47:44] zero
  output logic [47:0]                    m_axis_tdata,
  output logic                           m_axis_tuser,   // [0] drained
  input  logic                           cfg_we,
  input  logic [fta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fta_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  localparam int DTW = (TIME_BITS < fta_pkg::FRAME_W) ? TIME_BITS : fta_pkg::FRAME_W;
  localparam int AW  = ((DTW > fta_pkg::STEP_W) ? DTW : fta_pkg::STEP_W) + 1;
  localparam int CW  = $clog2(AW + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_QUOT = 4'b0010,
    S_FRAC = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  fta_pkg::fta_cfg_t      cfg;
  fta_pkg::fta_div_stat_t div_stat;

  state_t state;
  state_t state_next;

  logic [fta_pkg::STEP_W-1:0]  accum_time;
  logic [fta_pkg::CAP_W-1:0]   count_r;
  logic [fta_pkg::STEP_W-1:0]  rem_r;
  logic [fta_pkg::ALPHA_W-1:0] alpha_r;
  logic                        drained_r;

  logic [fta_pkg::CAP_W-1:0]   out_count;
  logic [fta_pkg::STEP_W-1:0]  out_rem;
  logic [fta_pkg::ALPHA_W-1:0] out_alpha;
  logic                        out_drained;
  logic                        out_valid;

  logic [DTW-1:0]              dt;
  logic [DTW-1:0]              limit;
  logic [DTW-1:0]              dt_clamped;
  logic [AW-1:0]               acc;

  logic                        in_fire;
  logic                        out_free;
  logic                        div_start;
  logic [fta_pkg::STEP_W-1:0]  div_rem_init;
  logic [AW-1:0]               div_dividend;
  logic [CW-1:0]               div_nbits;
  logic [AW-1:0]               div_quo;
  logic [fta_pkg::STEP_W-1:0]  div_rem;
  logic                        over_cap;

  fta_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign dt         = s_axis_tdata[DTW-1:0];
  assign limit      = cfg.max_frame[DTW-1:0];
  assign dt_clamped = (dt > limit) ? limit : dt;
  assign acc        = AW'(accum_time) + AW'(dt_clamped);

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid | m_axis_tready;
  assign over_cap      = div_quo > AW'(cfg.max_steps);

  // first pass divides the accumulator, second continues from its remainder
  always_comb begin
    div_start    = 1'b0;
    div_rem_init = '0;
    div_dividend = acc;
    div_nbits    = CW'(AW);
    if (state == S_IDLE) begin
      div_start = in_fire;
    end else if (state == S_QUOT) begin
      div_start    = div_stat.done;
      div_rem_init = div_rem;
      div_dividend = '0;
      div_nbits    = CW'(fta_pkg::ALPHA_W);
    end
  end

  fta_div #(
    .DW (AW),
    .CW (CW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .rem_init  (div_rem_init),
    .dividend  (div_dividend),
    .nbits     (div_nbits),
    .divisor   (cfg.fixed_step),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_QUOT;
      S_QUOT: if (div_stat.done) state_next = S_FRAC;
      S_FRAC: if (div_stat.done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      accum_time <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_QUOT && div_stat.done) begin
        accum_time <= div_rem;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_QUOT && div_stat.done) begin
      // saturate the step count at the cap; any excess is drained
      count_r   <= over_cap ? cfg.max_steps : div_quo[fta_pkg::CAP_W-1:0];
      drained_r <= over_cap;
      rem_r     <= div_rem;
    end
    if (state == S_FRAC && div_stat.done) begin
      alpha_r <= div_quo[fta_pkg::ALPHA_W-1:0];
    end
    if (state == S_DONE && out_free) begin
      out_count   <= count_r;
      out_rem     <= rem_r;
      out_alpha   <= alpha_r;
      out_drained <= drained_r;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_alpha, out_rem, out_count};
  assign m_axis_tuser  = out_drained;

`ifndef SYNTHESIS
  a_ready_not_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (div_stat.busy && state == S_QUOT))
    else $error("accepted transaction did not start the divider");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |=> !div_stat.done)
    else $error("divider done held longer than one cycle");

  a_drain_at_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && drained_r) |-> (count_r == cfg.max_steps))
    else $error("drained without step count at cap");

  a_rem_below_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (rem_r < cfg.fixed_step))
    else $error("remainder not below fixed step");
`endif

endmodule
